>>> hdl/grlp_pkg.sv
// Shared types and constants of the gamepad record line parser.
package grlp_pkg;

  typedef enum logic [2:0] {
    PH_LINE_START,
    PH_SKIP,
    PH_CMD_LEAD,
    PH_CMD_SIGN,
    PH_CMD_DIGITS,
    PH_PAD0,
    PH_PAD1
  } phase_t;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_BAD_COMMAND   = 3'd1,
    ST_NO_PAD0_BAR   = 3'd2,
    ST_PAD0_LENGTH   = 3'd3,
    ST_PAD1_MISMATCH = 3'd4
  } status_t;

  localparam logic [7:0] BAR_CHAR     = 8'h7C;
  localparam logic [7:0] DOT_CHAR     = 8'h2E;
  localparam logic [7:0] SPACE_CHAR   = 8'h20;
  localparam logic [7:0] NEWLINE_CHAR = 8'h0A;
  localparam logic [7:0] NUL_CHAR     = 8'h00;
  localparam logic [7:0] PLUS_CHAR    = 8'h2B;
  localparam logic [7:0] MINUS_CHAR   = 8'h2D;
  localparam logic [7:0] ZERO_CHAR    = 8'h30;
  localparam logic [7:0] NINE_CHAR    = 8'h39;
  localparam logic [7:0] TAB_CHAR     = 8'h09;
  localparam logic [7:0] CR_CHAR      = 8'h0D;

  localparam logic [3:0] PAD_WIDTH   = 4'd8;
  localparam logic [3:0] PAD_CNT_MAX = 4'd9;

  localparam int unsigned CFG_ADDR_W = 3;
  localparam int unsigned CFG_DATA_W = 32;
  localparam logic [CFG_ADDR_W-3:0] REG_SECOND_PAD_IDX = '0;

  typedef struct packed {
    logic        fire;
    status_t     status;
    logic [31:0] parsed_command;
    logic [7:0]  pad0_buttons;
    logic [7:0]  pad1_buttons;
    logic [31:0] frame_number;
  } result_t;

endpackage

>>> hdl/grlp_parser.sv
// Per-byte record parser: line phase, command accumulator, pad fields, record count.
module grlp_parser (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               advance,
  input  logic [7:0]         data_byte,
  input  logic               second_pad_present,
  output grlp_pkg::result_t  res
);

  grlp_pkg::phase_t phase_r, phase_nxt;
  logic [63:0] acc_r, acc_nxt;
  logic        minus_r, minus_nxt;
  logic        digit_seen_r, digit_seen_nxt;
  logic        ovf_r, ovf_nxt;
  logic [3:0]  cnt_r, cnt_nxt;
  logic [7:0]  pad0_r, pad0_nxt;
  logic [7:0]  pad1_r, pad1_nxt;
  logic [31:0] good_cnt_r, good_cnt_nxt;

  logic        eol, cut, is_bar, is_digit, is_ws, is_sign, pressed;
  logic [67:0] acc_x10;
  logic [63:0] dig_acc;
  logic        dig_ovf;
  logic [7:0]  pad_mask;
  logic [3:0]  cnt_inc;
  logic        pad1_len_ok;

  assign eol      = (data_byte == grlp_pkg::NEWLINE_CHAR);
  assign cut      = (data_byte == grlp_pkg::NUL_CHAR);
  assign is_bar   = (data_byte == grlp_pkg::BAR_CHAR);
  assign is_digit = (data_byte >= grlp_pkg::ZERO_CHAR) && (data_byte <= grlp_pkg::NINE_CHAR);
  assign is_ws    = (data_byte == grlp_pkg::SPACE_CHAR) ||
                    ((data_byte >= grlp_pkg::TAB_CHAR) && (data_byte <= grlp_pkg::CR_CHAR));
  assign is_sign  = (data_byte == grlp_pkg::PLUS_CHAR) || (data_byte == grlp_pkg::MINUS_CHAR);
  assign pressed  = (data_byte != grlp_pkg::DOT_CHAR) && (data_byte != grlp_pkg::SPACE_CHAR);

  // Times ten as two shifts and an add; any carry into the top four bits is an overflow.
  assign acc_x10 = ({4'b0, acc_r} << 3) + ({4'b0, acc_r} << 1) + {64'b0, data_byte[3:0]};
  assign dig_ovf = ovf_r || (acc_x10[67:64] != 4'b0);
  assign dig_acc = dig_ovf ? acc_r : acc_x10[63:0];

  assign pad_mask    = ((cnt_r < grlp_pkg::PAD_WIDTH) && pressed) ? (8'b1 << cnt_r[2:0]) : 8'b0;
  assign cnt_inc     = (cnt_r < grlp_pkg::PAD_CNT_MAX) ? cnt_r + 4'd1 : cnt_r;
  assign pad1_len_ok = second_pad_present ? (cnt_r == grlp_pkg::PAD_WIDTH) : (cnt_r == 4'd0);

  // Phase transitions
  always_comb begin
    phase_nxt = phase_r;
    case (phase_r)
      grlp_pkg::PH_LINE_START: begin
        if (is_bar) phase_nxt = grlp_pkg::PH_CMD_LEAD;
        else if (!eol) phase_nxt = grlp_pkg::PH_SKIP;
      end
      grlp_pkg::PH_SKIP: begin
        if (eol) phase_nxt = grlp_pkg::PH_LINE_START;
      end
      grlp_pkg::PH_CMD_LEAD, grlp_pkg::PH_CMD_SIGN, grlp_pkg::PH_CMD_DIGITS,
      grlp_pkg::PH_PAD0, grlp_pkg::PH_PAD1: begin
        if (eol) begin
          phase_nxt = grlp_pkg::PH_LINE_START;
        end else if (cut) begin
          phase_nxt = grlp_pkg::PH_SKIP;
        end else begin
          case (phase_r)
            grlp_pkg::PH_CMD_LEAD: begin
              if (is_sign) phase_nxt = grlp_pkg::PH_CMD_SIGN;
              else if (is_digit) phase_nxt = grlp_pkg::PH_CMD_DIGITS;
              else if (!is_ws) phase_nxt = grlp_pkg::PH_SKIP;
            end
            grlp_pkg::PH_CMD_SIGN: begin
              phase_nxt = is_digit ? grlp_pkg::PH_CMD_DIGITS : grlp_pkg::PH_SKIP;
            end
            grlp_pkg::PH_CMD_DIGITS: begin
              if (!is_digit) begin
                phase_nxt = (is_bar && !ovf_r && digit_seen_r) ? grlp_pkg::PH_PAD0
                                                               : grlp_pkg::PH_SKIP;
              end
            end
            grlp_pkg::PH_PAD0: begin
              if (is_bar) begin
                phase_nxt = (cnt_r == grlp_pkg::PAD_WIDTH) ? grlp_pkg::PH_PAD1
                                                           : grlp_pkg::PH_SKIP;
              end
            end
            default: begin
              if (is_bar) phase_nxt = grlp_pkg::PH_SKIP;
            end
          endcase
        end
      end
      default: begin
        if (eol) phase_nxt = grlp_pkg::PH_LINE_START;
      end
    endcase
  end

  // Record data and result
  always_comb begin
    acc_nxt            = acc_r;
    minus_nxt          = minus_r;
    digit_seen_nxt     = digit_seen_r;
    ovf_nxt            = ovf_r;
    cnt_nxt            = cnt_r;
    pad0_nxt           = pad0_r;
    pad1_nxt           = pad1_r;
    good_cnt_nxt       = good_cnt_r;
    res.fire           = 1'b0;
    res.status         = grlp_pkg::ST_OK;
    res.parsed_command = 32'd0;
    res.pad0_buttons   = 8'd0;
    res.pad1_buttons   = 8'd0;
    res.frame_number   = good_cnt_r;
    case (phase_r)
      grlp_pkg::PH_LINE_START: begin
        if (is_bar) begin
          acc_nxt        = 64'd0;
          minus_nxt      = 1'b0;
          digit_seen_nxt = 1'b0;
          ovf_nxt        = 1'b0;
          cnt_nxt        = 4'd0;
          pad0_nxt       = 8'd0;
          pad1_nxt       = 8'd0;
        end
      end
      grlp_pkg::PH_SKIP: begin
        acc_nxt = acc_r;
      end
      default: begin
        if (eol || cut) begin
          res.fire = 1'b1;
          if (phase_r == grlp_pkg::PH_PAD0) res.status = grlp_pkg::ST_NO_PAD0_BAR;
          else if (phase_r == grlp_pkg::PH_PAD1) res.status = grlp_pkg::ST_PAD1_MISMATCH;
          else res.status = grlp_pkg::ST_BAD_COMMAND;
        end else begin
          case (phase_r)
            grlp_pkg::PH_CMD_LEAD, grlp_pkg::PH_CMD_SIGN, grlp_pkg::PH_CMD_DIGITS: begin
              if (is_digit) begin
                digit_seen_nxt = 1'b1;
                ovf_nxt        = dig_ovf;
                acc_nxt        = dig_acc;
              end else if (is_sign && (phase_r == grlp_pkg::PH_CMD_LEAD)) begin
                minus_nxt = (data_byte == grlp_pkg::MINUS_CHAR);
              end else if (is_ws && (phase_r == grlp_pkg::PH_CMD_LEAD)) begin
                acc_nxt = acc_r;
              end else if ((phase_r == grlp_pkg::PH_CMD_DIGITS) && is_bar &&
                           !ovf_r && digit_seen_r) begin
                cnt_nxt = 4'd0;
              end else begin
                res.fire   = 1'b1;
                res.status = grlp_pkg::ST_BAD_COMMAND;
              end
            end
            grlp_pkg::PH_PAD0: begin
              if (!is_bar) begin
                pad0_nxt = pad0_r | pad_mask;
                cnt_nxt  = cnt_inc;
              end else if (cnt_r == grlp_pkg::PAD_WIDTH) begin
                cnt_nxt = 4'd0;
              end else begin
                res.fire   = 1'b1;
                res.status = grlp_pkg::ST_PAD0_LENGTH;
              end
            end
            default: begin
              if (!is_bar) begin
                pad1_nxt = pad1_r | pad_mask;
                cnt_nxt  = cnt_inc;
              end else if (!pad1_len_ok) begin
                res.fire   = 1'b1;
                res.status = grlp_pkg::ST_PAD1_MISMATCH;
              end else begin
                // Only the low half of a negated 64-bit value is kept.
                res.fire           = 1'b1;
                res.status         = grlp_pkg::ST_OK;
                res.parsed_command = minus_r ? (32'd0 - acc_r[31:0]) : acc_r[31:0];
                res.pad0_buttons   = pad0_r;
                res.pad1_buttons   = second_pad_present ? pad1_r : 8'd0;
                good_cnt_nxt       = good_cnt_r + 32'd1;
              end
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r      <= grlp_pkg::PH_LINE_START;
      minus_r      <= 1'b0;
      digit_seen_r <= 1'b0;
      ovf_r        <= 1'b0;
      cnt_r        <= 4'd0;
      pad0_r       <= 8'd0;
      pad1_r       <= 8'd0;
      good_cnt_r   <= 32'd0;
    end else if (advance) begin
      phase_r      <= phase_nxt;
      minus_r      <= minus_nxt;
      digit_seen_r <= digit_seen_nxt;
      ovf_r        <= ovf_nxt;
      cnt_r        <= cnt_nxt;
      pad0_r       <= pad0_nxt;
      pad1_r       <= pad1_nxt;
      good_cnt_r   <= good_cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      acc_r <= acc_nxt;
    end
  end

  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (res.fire && (res.status != grlp_pkg::ST_OK)) |->
      (res.parsed_command == 32'd0) && (res.pad0_buttons == 8'd0) && (res.pad1_buttons == 8'd0))
    else $error("error result carries non-zero payload");

  a_after_result: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.fire) |=>
      (phase_r == grlp_pkg::PH_SKIP) || (phase_r == grlp_pkg::PH_LINE_START))
    else $error("parser did not leave the record after a result");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (advance && res.fire && (res.status == grlp_pkg::ST_OK)) |=>
      (good_cnt_r == $past(good_cnt_r) + 32'd1))
    else $error("good record count did not advance");

  a_line_start_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (phase_r == grlp_pkg::PH_LINE_START) |-> !res.fire)
    else $error("result raised at the first byte of a line");

endmodule

>>> hdl/gamepad_record_line_parser.sv
// Top level of the gamepad record line parser: channels, register port and result register.
//
// The input channel takes one byte of a text movie log per word (in_valid, in_ready,
// in_data_byte). Lines starting with '|' are parsed as records |command|pad0|pad1|;
// other lines are skipped. For each record, or at the first error in it, one word
// appears on the result channel with a status code, the command value, both pad
// button masks and the count of good records before it.
// A byte is held in an input register and parsed combinationally; the result it makes is
// registered in the result register and taken from there. One byte per cycle is sustained
// while out_ready stays high, since the parse step itself never holds a byte back.
// While a result waits with out_ready low, the held byte is not parsed, whether or not it
// makes a result, so in_ready drops once the input register is full; when out_ready
// rises the result leaves and the held byte is parsed at the same edge. Register 0
// (second_pad_present) sits at byte addresses 0 to 3 of the APB-style port, read back there.
// Reset (rst_n low, synchronous) returns to the start of a line, clears the good record
// count and the register, and empties both the input and result registers.
module gamepad_record_line_parser (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      in_data_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [2:0]                      out_status,
  output logic [31:0]                     out_parsed_command,
  output logic [7:0]                      out_pad0_buttons,
  output logic [7:0]                      out_pad1_buttons,
  output logic [31:0]                     out_frame_number,
  input  logic                            cfg_psel,
  input  logic                            cfg_penable,
  input  logic                            cfg_pwrite,
  input  logic [grlp_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [grlp_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [grlp_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                            cfg_pready
);

  logic              second_pad_r;
  logic              reg_hit;
  logic              in_vld_r;
  logic [7:0]        in_byte_r;
  logic              out_vld_r;
  logic              advance;
  grlp_pkg::result_t res;
  grlp_pkg::result_t out_r;

  assign cfg_pready = 1'b1;
  assign reg_hit    = (cfg_paddr[grlp_pkg::CFG_ADDR_W-1:2] == grlp_pkg::REG_SECOND_PAD_IDX);
  assign cfg_prdata = reg_hit ? {{(grlp_pkg::CFG_DATA_W-1){1'b0}}, second_pad_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      second_pad_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && reg_hit) begin
      second_pad_r <= cfg_pwdata[0];
    end
  end

  // The held word is parsed when the result register is free or being emptied.
  assign advance  = in_vld_r && (!out_vld_r || out_ready);
  assign in_ready = !in_vld_r || advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_ready) begin
      in_vld_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_byte_r <= in_data_byte;
    end
  end

  grlp_parser u_parser (
    .clk                (clk),
    .rst_n              (rst_n),
    .advance            (advance),
    .data_byte          (in_byte_r),
    .second_pad_present (second_pad_r),
    .res                (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (advance && res.fire) begin
      out_vld_r <= 1'b1;
    end else if (out_ready) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && res.fire) begin
      out_r <= res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_status         = out_r.status;
  assign out_parsed_command = out_r.parsed_command;
  assign out_pad0_buttons   = out_r.pad0_buttons;
  assign out_pad1_buttons   = out_r.pad1_buttons;
  assign out_frame_number   = out_r.frame_number;

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (out_vld_r && !out_ready) |-> !advance)
    else $error("result register overwritten while stalled");

  a_parse_held: assert property (@(posedge clk) disable iff (!rst_n)
    (in_vld_r && !advance) |=> in_vld_r && $stable(in_byte_r))
    else $error("held input word lost before parsing");

  a_status_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> (out_status <= 3'd4))
    else $error("result status out of range");

endmodule
